>>> rtl/erol_pkg.sv
// Shared types and constants for the entry ring offset lookup block.
`default_nettype none

package erol_pkg;

    localparam int LEN_W  = 16;
    localparam int POS_W  = 20;
    localparam int SLOT_IDX_W = 4;

    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } erol_state_t;

endpackage

`default_nettype wire

>>> rtl/erol_req_if.sv
// Request channel interface: mode, entry length and byte position.
`default_nettype none

interface erol_req_if;
    import erol_pkg::*;

    logic valid;
    logic ready;
    logic mode;
    len_t entry_length;
    pos_t byte_position;

    modport source (output valid, output mode, output entry_length, output byte_position,
                    input ready);
    modport sink (input valid, input mode, input entry_length, input byte_position,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/erol_rsp_if.sv
// Response channel interface: lookup and add results.
`default_nettype none

interface erol_rsp_if;
    import erol_pkg::*;

    logic      valid;
    logic      ready;
    logic      found;
    slot_idx_t slot_index;
    len_t      offset_in_entry;
    logic      overwrote;

    modport source (output valid, output found, output slot_index, output offset_in_entry,
                    output overwrote, input ready);
    modport sink (input valid, input found, input slot_index, input offset_in_entry,
                  input overwrote, output ready);
endinterface

`default_nettype wire

>>> rtl/entry_ring_offset_lookup.sv
// Overwriting ring of entry lengths with a byte offset lookup.
//
// The req channel carries one beat per operation. An add beat stores its
// length at the write slot and, once the ring is full, replaces the oldest
// entry. A find beat walks the stored lengths from oldest to newest and
// reports the slot whose byte range holds the offset, plus the offset inside
// that entry. Each req beat yields exactly one rsp beat.
// The lengths live in a synchronous memory read once per cycle, and a find
// visits the stored entries one at a time from oldest to newest. The next
// req beat is taken once the result has moved into the output register.
// The output register holds a finished beat while the receiver stalls; a new
// req beat can be taken and worked on meanwhile, and its result waits until
// the output register is free.
// Reset empties the ring by clearing the slot pointers and the full flag; the
// memory itself is not cleared, since only written entries are ever read.
`default_nettype none

module entry_ring_offset_lookup #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    erol_req_if.sink   req,
    erol_rsp_if.source rsp
);
    import erol_pkg::*;

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = SLOT_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(RING_DEPTH);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    erol_state_t state_reg, state_next;

    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0] old_slot_reg, old_slot_next;
    logic              full_reg, full_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    pos_t              sum_reg, sum_next;
    pos_t              pos_reg, pos_next;

    logic              res_found_reg, res_found_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    len_t              res_offs_reg, res_offs_next;
    logic              res_over_reg, res_over_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    slot_idx_t         out_slot_reg, out_slot_next;
    len_t              out_offs_reg, out_offs_next;
    logic              out_over_reg, out_over_next;

    len_t              length_mem [RING_DEPTH];
    len_t              rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;

    logic              accept;
    logic [CNT_W-1:0]  count;
    logic [POS_W:0]    sum_ext;
    logic              hit;
    logic              out_free;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign sum_ext  = {1'b0, sum_reg} + (POS_W+1)'(rd_data_reg);
    assign hit      = sum_ext > {1'b0, pos_reg};

    always_comb
    begin
        if (full_reg)
        begin
            count = DEPTH_CNT;
        end
        else if (wr_slot_reg >= old_slot_reg)
        begin
            count = CNT_W'(wr_slot_reg) - CNT_W'(old_slot_reg);
        end
        else
        begin
            count = CNT_W'(wr_slot_reg) + DEPTH_CNT - CNT_W'(old_slot_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            length_mem[mem_waddr] <= req.entry_length;
        end
        rd_data_reg <= length_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.mode == MODE_FIND && count != '0)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_WALK:
            begin
                if (hit || remain_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready      = (state_reg == ST_IDLE);
        wr_slot_next   = wr_slot_reg;
        old_slot_next  = old_slot_reg;
        full_next      = full_reg;
        cur_slot_next  = cur_slot_reg;
        remain_next    = remain_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        res_found_next = res_found_reg;
        res_slot_next  = res_slot_reg;
        res_offs_next  = res_offs_reg;
        res_over_next  = res_over_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_found_next = out_found_reg;
        out_slot_next  = out_slot_reg;
        out_offs_next  = out_offs_reg;
        out_over_next  = out_over_reg;
        rd_addr        = cur_slot_reg;
        mem_we         = 1'b0;
        mem_waddr      = full_reg ? old_slot_reg : wr_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == MODE_ADD)
                    begin
                        mem_we         = 1'b1;
                        res_found_next = 1'b0;
                        res_slot_next  = mem_waddr;
                        res_offs_next  = '0;
                        res_over_next  = full_reg;
                        wr_slot_next   = next_slot(wr_slot_reg);
                        if (full_reg)
                        begin
                            old_slot_next = next_slot(old_slot_reg);
                        end
                        else
                        begin
                            full_next = (next_slot(wr_slot_reg) == old_slot_reg);
                        end
                    end
                    else
                    begin
                        res_found_next = 1'b0;
                        res_slot_next  = '0;
                        res_offs_next  = '0;
                        res_over_next  = 1'b0;
                        pos_next       = req.byte_position;
                        sum_next       = '0;
                        cur_slot_next  = old_slot_reg;
                        remain_next    = count;
                        rd_addr        = old_slot_reg;
                    end
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_slot_next  = cur_slot_reg;
                    res_offs_next  = LEN_W'(pos_reg - sum_reg);
                end
                else if (remain_reg != CNT_W'(1))
                begin
                    sum_next      = sum_ext[POS_W-1:0];
                    cur_slot_next = next_slot(cur_slot_reg);
                    remain_next   = remain_reg - 1'b1;
                    rd_addr       = next_slot(cur_slot_reg);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_slot_next  = SLOT_IDX_W'(res_slot_reg);
                    out_offs_next  = res_offs_reg;
                    out_over_next  = res_over_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_slot_reg   <= '0;
            old_slot_reg  <= '0;
            full_reg      <= 1'b0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_slot_reg   <= wr_slot_next;
            old_slot_reg  <= old_slot_next;
            full_reg      <= full_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_slot_reg  <= cur_slot_next;
        sum_reg       <= sum_next;
        pos_reg       <= pos_next;
        res_found_reg <= res_found_next;
        res_slot_reg  <= res_slot_next;
        res_offs_reg  <= res_offs_next;
        res_over_reg  <= res_over_next;
        out_found_reg <= out_found_next;
        out_slot_reg  <= out_slot_next;
        out_offs_reg  <= out_offs_next;
        out_over_reg  <= out_over_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.found           = out_found_reg;
    assign rsp.slot_index      = out_slot_reg;
    assign rsp.offset_in_entry = out_offs_reg;
    assign rsp.overwrote       = out_over_reg;

`ifndef NO_ASSERTIONS
    // A full ring always has its write slot on the oldest entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> wr_slot_reg == old_slot_reg)
        else $error("full ring with write slot away from oldest slot");

    // The oldest slot only moves once the ring has filled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !full_reg |-> old_slot_reg == '0)
        else $error("oldest slot moved before the ring filled");

    // A walk never runs with no entries left to visit.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> remain_reg != '0)
        else $error("walk with no entries left");

    // An accepted add goes straight to the result stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode == MODE_ADD) |=> state_reg == ST_EMIT)
        else $error("add beat did not reach the result stage");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the entry ring offset lookup block.
module tb;
    import erol_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = RING_DEPTH + 8;
    localparam int PHASE_ITEMS = 215;

    typedef struct packed {
        logic      found;
        slot_idx_t slot_index;
        len_t      offset_in_entry;
        logic      overwrote;
    } lookup_result_t;

    class entry_ring_tracker;
        len_t           lengths[RING_DEPTH];
        int unsigned    write_slot;
        int unsigned    oldest_slot;
        bit             ring_full;
        lookup_result_t expected_results[$];
        int             mismatch_count;
        int             add_count;
        int             overwrite_count;
        int             find_count;
        int             hit_count;

        function int unsigned entry_count();
            if (ring_full)
                return RING_DEPTH;
            return (write_slot + RING_DEPTH - oldest_slot) % RING_DEPTH;
        endfunction

        function int unsigned entry_start(int unsigned k);
            int unsigned sum;
            int unsigned s;
            sum = 0;
            s = oldest_slot;
            for (int unsigned i = 0; i < k; i++)
            begin
                sum += lengths[s];
                s = (s + 1) % RING_DEPTH;
            end
            return sum;
        endfunction

        function void note_request(logic mode, len_t entry_length, pos_t byte_position);
            lookup_result_t r;
            int unsigned    s;
            int unsigned    count;
            int unsigned    sum;
            r = '0;
            if (mode == MODE_ADD)
            begin
                add_count++;
                s = ring_full ? oldest_slot : write_slot;
                lengths[s] = entry_length;
                r.slot_index = slot_idx_t'(s);
                if (ring_full)
                begin
                    r.overwrote = 1'b1;
                    overwrite_count++;
                    oldest_slot = (oldest_slot + 1) % RING_DEPTH;
                    write_slot = (write_slot + 1) % RING_DEPTH;
                end
                else
                begin
                    write_slot = (write_slot + 1) % RING_DEPTH;
                    ring_full = (write_slot == oldest_slot);
                end
            end
            else
            begin
                find_count++;
                count = entry_count();
                s = oldest_slot;
                sum = 0;
                for (int unsigned i = 0; i < count; i++)
                begin
                    if (sum + lengths[s] > byte_position)
                    begin
                        r.found = 1'b1;
                        r.slot_index = slot_idx_t'(s);
                        r.offset_in_entry = len_t'(byte_position - sum);
                        hit_count++;
                        break;
                    end
                    sum += lengths[s];
                    s = (s + 1) % RING_DEPTH;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, got %p", $time, got);
                return;
            end
            want = expected_results.pop_front();
            check_field("found", want.found, got.found);
            check_field("slot_index", want.slot_index, got.slot_index);
            check_field("offset_in_entry", want.offset_in_entry, got.offset_in_entry);
            check_field("overwrote", want.overwrote, got.overwrote);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles = 0;
    int   quiet_cycles = 0;

    entry_ring_tracker tracker = new();

    erol_req_if req_ch();
    erol_rsp_if rsp_ch();

    entry_ring_offset_lookup #(
        .RING_DEPTH(RING_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_result({rsp_ch.found, rsp_ch.slot_index,
                                      rsp_ch.offset_in_entry, rsp_ch.overwrote});
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_beat(logic mode, len_t entry_length, pos_t byte_position);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.entry_length <= entry_length;
        req_ch.byte_position <= byte_position;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.note_request(mode, entry_length, byte_position);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        int unsigned total;
        int          boundary;
        len_t        entry_length;
        pos_t        byte_position;
        pick = $urandom_range(99);
        if (pick < 30)
            entry_length = len_t'($urandom_range(3));
        else if (pick < 70)
            entry_length = len_t'($urandom_range(4095));
        else
            entry_length = len_t'($urandom);
        byte_position = pos_t'($urandom);
        if ($urandom_range(99) < 55)
        begin
            send_beat(MODE_ADD, entry_length, byte_position);
            return;
        end
        total = tracker.entry_start(tracker.entry_count());
        pick = $urandom_range(99);
        if (pick < 55 && total > 0)
            byte_position = pos_t'($urandom_range(total - 1));
        else if (pick < 80)
        begin
            boundary = tracker.entry_start($urandom_range(tracker.entry_count()));
            byte_position = pos_t'(boundary + $urandom_range(2) - 1);
        end
        send_beat(MODE_FIND, entry_length, byte_position);
    endtask

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.mode <= MODE_ADD;
        req_ch.entry_length <= '0;
        req_ch.byte_position <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(MODE_FIND, 16'h0000, 20'h00000);
        send_beat(MODE_FIND, 16'hFFFF, 20'hFFFFF);
        send_beat(MODE_ADD, 16'h0000, 20'hFFFFF);
        send_beat(MODE_ADD, 16'hFFFF, 20'h00000);
        send_beat(MODE_ADD, 16'h0001, 20'h12345);
        send_beat(MODE_FIND, 16'h0000, 20'd0);
        send_beat(MODE_FIND, 16'h0000, 20'd65534);
        send_beat(MODE_FIND, 16'h0000, 20'd65535);
        send_beat(MODE_FIND, 16'h0000, 20'd65536);
        for (int i = 0; i < 15; i++)
            send_beat(MODE_ADD, (i % 3 == 0) ? 16'hFFFF : len_t'(i * 4097), pos_t'(i));
        send_beat(MODE_FIND, 16'h0000, 20'hFFFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 63 : (phase == 3) ? 14 : 0;
            recv_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 14 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_item();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 200;
        for (int i = 0; i < 40; i++)
            send_random_item();
        req_ch.valid <= 1'b0;

        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d adds (%0d overwriting the oldest entry) and %0d finds (%0d hits),",
                 tracker.add_count, tracker.overwrite_count, tracker.find_count,
                 tracker.hit_count);
        $display("under four idle profiles and one long receiver stall.");
        if (tracker.mismatch_count == 0 && tracker.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
